@@ rtl/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way sorted list merge unit.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TUSER_W = 3;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [APB_ADDR_W-1:0] REG_LISTS_IN_USE = 3'd0;
	localparam logic [3:0]            LISTS_RESET      = 4'd8;

	// result status codes
	localparam logic [2:0] ST_APPENDED  = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_MERGED    = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;

	typedef enum logic [1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_MERGE  = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef struct packed {
		logic capture;     // latch input beat
		logic append;      // store value_q into its list
		logic clear;       // empty all lists
		logic scan_step;   // compare one head against the running best
		logic advance;     // bump winner's read position, fetch next head
		logic load_head;   // write fetched word into head register
		logic set_result;  // move result into the output register
	} kwm_cmd_t;

endpackage

@@ rtl/kwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer: decodes func, steps the head scan and owns the output valid.
// ----------------------------------------------------------------------------
module kwm_ctrl
	import kwm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  func_t    in_func,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  logic     scan_last,
	output kwm_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPEND,
		S_CLEAR,
		S_SCAN,
		S_ADV,
		S_LOAD,
		S_DONE
	} state_t;

	state_t state_q;
	logic   m_valid_q;
	logic   out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == S_IDLE) && s_tvalid;
		cmd.append     = (state_q == S_APPEND);
		cmd.clear      = (state_q == S_CLEAR);
		cmd.scan_step  = (state_q == S_SCAN);
		cmd.advance    = (state_q == S_ADV);
		cmd.load_head  = (state_q == S_LOAD);
		cmd.set_result = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.set_result) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						unique case (in_func)
							FUNC_APPEND: state_q <= S_APPEND;
							FUNC_MERGE:  state_q <= S_SCAN;
							FUNC_CLEAR:  state_q <= S_CLEAR;
							FUNC_NONE:   state_q <= S_IDLE;
						endcase
					end
				end
				S_APPEND: state_q <= S_DONE;
				S_CLEAR:  state_q <= S_DONE;
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_ADV;
					end
				end
				S_ADV:  state_q <= S_LOAD;
				S_LOAD: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/kwm_datapath.sv @@
// ----------------------------------------------------------------------------
// kwm_datapath
// List store, per-list fill/read counters, head registers, scan compare and
// result register.
// ----------------------------------------------------------------------------
module kwm_datapath
	import kwm_pkg::*;
#(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kwm_cmd_t           cmd,
	input  func_t              in_func,
	input  logic [2:0]         in_list_id,
	input  logic signed [31:0] in_value,
	input  logic [3:0]         lists_in_use,
	output logic               scan_last,
	output logic [2:0]         out_status,
	output logic signed [31:0] out_value,
	output logic [2:0]         out_source
);

	localparam int LW    = $clog2(NUM_LISTS);
	localparam int CW    = $clog2(LIST_DEPTH + 1);
	localparam int MDEP  = NUM_LISTS * LIST_DEPTH;
	localparam int MAW   = $clog2(MDEP);
	localparam int NW    = $clog2(NUM_LISTS + 1);
	localparam int KW    = (NW > 4) ? NW : 4;

	// captured item
	func_t              func_q;
	logic [2:0]         id_q;
	logic signed [31:0] value_q;

	logic [CW-1:0]      fill_q [NUM_LISTS];
	logic [CW-1:0]      rp_q   [NUM_LISTS];
	logic signed [31:0] head_q [NUM_LISTS];
	logic signed [31:0] mem    [MDEP];
	logic signed [31:0] rd_data_q;

	logic [LW-1:0]      idx_q;
	logic [LW-1:0]      best_idx_q;
	logic signed [31:0] best_val_q;
	logic               found_q;
	logic               more_q;
	logic               append_ok_q;

	logic [LW-1:0]      aidx;
	logic [CW-1:0]      afill;
	logic               id_ok;
	logic               append_ok;
	logic [MAW-1:0]     waddr;
	logic [LW-1:0]      last_idx;
	logic [KW-1:0]      lists_ext;
	logic               take;
	logic [CW-1:0]      rp_next;
	logic               more;
	logic [MAW-1:0]     raddr;
	logic [2:0]         status_nxt;

	// append path
	assign aidx      = LW'(id_q);
	assign id_ok     = KW'(id_q) < KW'(NUM_LISTS);
	assign afill     = fill_q[aidx];
	assign append_ok = id_ok && (afill < CW'(LIST_DEPTH));
	assign waddr     = MAW'(aidx) * MAW'(LIST_DEPTH) + MAW'(afill);

	// number of lists taking part, clamped to 1..NUM_LISTS
	assign lists_ext = KW'(lists_in_use);
	always_comb begin
		priority if (lists_ext == '0) begin
			last_idx = '0;
		end else if (lists_ext > KW'(NUM_LISTS)) begin
			last_idx = LW'(NUM_LISTS - 1);
		end else begin
			last_idx = LW'(lists_ext - KW'(1));
		end
	end
	assign scan_last = (idx_q == last_idx);

	// ties go to the later list
	assign take = (rp_q[idx_q] != fill_q[idx_q]) &&
	              (!found_q || (head_q[idx_q] <= best_val_q));

	assign rp_next = rp_q[best_idx_q] + CW'(1);
	assign more    = rp_next < fill_q[best_idx_q];
	assign raddr   = MAW'(best_idx_q) * MAW'(LIST_DEPTH) + MAW'(rp_next);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= in_func;
			id_q    <= in_list_id;
			value_q <= in_value;
		end
		if (cmd.scan_step && take) begin
			best_idx_q <= idx_q;
			best_val_q <= head_q[idx_q];
		end
	end

	// list store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.append && append_ok) begin
			mem[waddr] <= value_q;
		end
		if (cmd.advance && found_q && more) begin
			rd_data_q <= mem[raddr];
		end
	end

	// head registers: filled directly on append into an empty list,
	// refilled from the store after a pop
	always_ff @(posedge clk) begin
		if (cmd.append && append_ok && (rp_q[aidx] == afill)) begin
			head_q[aidx] <= value_q;
		end
		if (cmd.load_head && more_q) begin
			head_q[best_idx_q] <= rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				fill_q[i] <= '0;
				rp_q[i]   <= '0;
			end
			idx_q       <= '0;
			found_q     <= 1'b0;
			more_q      <= 1'b0;
			append_ok_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.append) begin
				append_ok_q <= append_ok;
				if (append_ok) begin
					fill_q[aidx] <= afill + CW'(1);
				end
			end
			if (cmd.clear) begin
				for (int i = 0; i < NUM_LISTS; i++) begin
					fill_q[i] <= '0;
					rp_q[i]   <= '0;
				end
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + LW'(1);
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.advance) begin
				more_q <= found_q && more;
				if (found_q) begin
					rp_q[best_idx_q] <= rp_next;
				end
			end
		end
	end

	always_comb begin
		unique case (func_q)
			FUNC_APPEND: status_nxt = append_ok_q ? ST_APPENDED : ST_FULL;
			FUNC_MERGE:  status_nxt = found_q ? ST_MERGED : ST_EXHAUSTED;
			FUNC_CLEAR:  status_nxt = ST_CLEARED;
			FUNC_NONE:   status_nxt = ST_CLEARED;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.set_result) begin
			out_status <= status_nxt;
			out_value  <= found_q ? best_val_q : 32'sd0;
			out_source <= found_q ? 3'(best_idx_q) : 3'd0;
		end
	end

endmodule

@@ rtl/k_way_sorted_list_merge_unit.sv @@
// ----------------------------------------------------------------------------
// k_way_sorted_list_merge_unit
// Keeps NUM_LISTS bounded lists of signed 32-bit words (LIST_DEPTH each) and
// merges them into one ascending stream. Each input beat carries a func in
// s_tuser: append list_id/value (status appended, or full when the list has
// taken LIST_DEPTH appends since the last clear or list_id is out of range),
// take the smallest head among the first lists_in_use lists (merged, with
// value and source list; on equal heads the higher list wins; exhausted when
// all those lists are drained), or clear all lists. func 3 is dropped with no
// result. Every other beat gives exactly one result beat. Append and clear
// act in their own state; a merge scans the clamped lists_in_use count of
// lists: the current head of every list sits in a register and one head is
// compared per cycle against the running minimum, then the winning list's
// next word is fetched from the list store (registered read) into its head
// register. The result sits in an output register, so a waiting result does
// not hold off the next input beat; only a second result stalls behind it.
// lists_in_use (APB, byte address 0, bits 3:0, reset 8) must be written only
// while idle; the block itself does not enforce this. 0 acts as 1 and values
// above NUM_LISTS act as NUM_LISTS. There is no clearing pass after reset;
// the store is only read below fill counts.
// ----------------------------------------------------------------------------
module k_way_sorted_list_merge_unit
	import kwm_pkg::*;
#(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input beats
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] list_id, [34:3] value, rest zero
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // [1:0] func
	// result beats
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] merged_value, [34:32] source_list
	output logic [OUT_TUSER_W-1:0] m_tuser,   // [2:0] status
	// register port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	kwm_cmd_t           cmd;
	logic               scan_last;
	logic [3:0]         lists_q;
	logic [2:0]         out_status;
	logic signed [31:0] out_value;
	logic [2:0]         out_source;
	logic               reg_hit;

	// register file: a single 4-bit register, decoded on the word address
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_LISTS_IN_USE[APB_ADDR_W-1:2]);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? APB_DATA_W'(lists_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lists_q <= LISTS_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			lists_q <= pwdata[3:0];
		end
	end

	kwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.in_func   (func_t'(s_tuser[1:0])),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.scan_last (scan_last),
		.cmd       (cmd)
	);

	kwm_datapath #(
		.NUM_LISTS  (NUM_LISTS),
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_func      (func_t'(s_tuser[1:0])),
		.in_list_id   (s_tdata[2:0]),
		.in_value     (s_tdata[34:3]),
		.lists_in_use (lists_q),
		.scan_last    (scan_last),
		.out_status   (out_status),
		.out_value    (out_value),
		.out_source   (out_source)
	);

	// result beat packing
	assign m_tdata = {5'd0, out_source, out_value};
	assign m_tuser = out_status;

endmodule

@@ rtl/kwm_checker.sv @@
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks of the merge unit, bound to the top level.
// ----------------------------------------------------------------------------
module kwm_checker
	import kwm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [OUT_TUSER_W-1:0] m_tuser,
	input logic                   psel,
	input logic                   penable,
	input logic                   pwrite,
	input logic [APB_ADDR_W-1:0]  paddr,
	input logic [APB_DATA_W-1:0]  pwdata,
	input logic [APB_DATA_W-1:0]  prdata
);

	// stalled beat stays up
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// stalled beat keeps its payload
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// only a merged result carries a value and a source list
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_MERGED) |-> (m_tdata == '0))
		else $error("non-merge result with nonzero payload");

	// a written lists_in_use reads back
	a_reg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		arst_n && psel && penable && pwrite && (paddr == REG_LISTS_IN_USE)
		|=> (paddr != REG_LISTS_IN_USE) || (prdata[3:0] == $past(pwdata[3:0])))
		else $error("lists_in_use readback mismatch");

endmodule

bind k_way_sorted_list_merge_unit kwm_checker u_kwm_checker (.*);
